// ===== rtl/trzr_pkg.sv =====
// shared constants and payload types of the triangle z-buffer rasterizer
// no dependencies; every other file imports this package

package trzr_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int XW         = $clog2(MAX_WIDTH);
   localparam int YW         = $clog2(MAX_HEIGHT);
   localparam int AW         = XW + YW;

   localparam int CFG_W = 9;
   localparam int DW    = 24;   // depth, unsigned 16.8
   localparam int CW    = 32;   // packed color
   localparam int NWR   = 17;   // pixels written count
   localparam int EW    = 36;   // edge function value, signed
   localparam int MW    = 35;   // edge magnitude
   localparam int NW    = 62;   // depth numerator
   localparam int QW    = 25;   // quotient bits

   localparam logic [DW-1:0] FAR_DEPTH = 24'd2560000;
   localparam logic [CW-1:0] BG_COLOR  = 32'hff949494;

   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_DRAW  = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic [DW-1:0]      az;
      logic signed [15:0] bx;
      logic signed [15:0] by;
      logic [DW-1:0]      bz;
      logic signed [15:0] cx;
      logic signed [15:0] cy;
      logic [DW-1:0]      cz;
      logic [CW-1:0]      fill_color;
   } req_type;

   typedef struct packed {
      logic [CW-1:0]  pixel_color;
      logic [DW-1:0]  pixel_depth;
      logic [NWR-1:0] pixels_written;
      logic           skipped;
   } rsp_type;

endpackage

// ===== rtl/trzr_if.sv =====
// valid/ready channel interfaces for command items and result items
// depends on trzr_pkg for the payload types

interface trzr_req_if;
   import trzr_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface trzr_rsp_if;
   import trzr_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/triangle_zbuffer_rasterizer_core.sv =====
// triangle rasterizer with depth and color frame stores
// depends on trzr_pkg, trzr_if and trzr_div
//
// usage: one command item enters on req_bus (valid/ready); exactly one result
// item leaves on rsp_bus. frame_width / frame_height are written through the
// csr port (csr_we, csr_index, csr_wdata) while the block is idle.
// after reset the block clears both stores, one pixel a cycle, while
// req_bus.ready stays low. a clear command clears the stores the same way and
// then offers its result; a read goes through S_READ, S_RDMEM and S_RDOUT. a
// draw runs its setup (box, nine steps of the shared multiplier, area check),
// then tests each pixel of the clamped bounding box against the triangle; for
// each covered pixel it forms the depth products on the shared 25x25
// multiplier and waits on the bit-serial divider. one item is in work at a
// time; ready is high only while idle. the result stays in an output register
// until rsp_bus.ready takes it, and ready rises in the cycle after that, so a
// stalled receiver stalls the input.

module triangle_zbuffer_rasterizer_core (
   input  logic                       clock,
   input  logic                       reset,
   trzr_req_if.sink                   req_bus,
   trzr_rsp_if.source                 rsp_bus,
   input  logic                       csr_we,
   input  logic [0:0]                 csr_index,
   input  logic [trzr_pkg::CFG_W-1:0] csr_wdata
);
   import trzr_pkg::*;

   typedef enum logic [13:0] {
      S_CLEAR  = 14'b00000000000001,
      S_IDLE   = 14'b00000000000010,
      S_READ   = 14'b00000000000100,
      S_RDMEM  = 14'b00000000001000,
      S_RDOUT  = 14'b00000000010000,
      S_BOX    = 14'b00000000100000,
      S_SETUP  = 14'b00000001000000,
      S_CHECK  = 14'b00000010000000,
      S_TEST   = 14'b00000100000000,
      S_DEPTH  = 14'b00001000000000,
      S_DIV    = 14'b00010000000000,
      S_UPDATE = 14'b00100000000000,
      S_NEXT   = 14'b01000000000000,
      S_RESP   = 14'b10000000000000
   } state_type;

   localparam int NPIX = 1 << AW;

   // stores
   logic [DW-1:0] depth_mem [NPIX];
   logic [CW-1:0] color_mem [NPIX];
   logic [DW-1:0] depth_rd_ff;
   logic [CW-1:0] color_rd_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [DW-1:0] mem_wdepth;
   logic [CW-1:0] mem_wcolor;

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CFG_W-1:0]  fw_ff, fh_ff;
   logic [XW-1:0]     x_ff, x_in, x0_ff, x0_in, x1_ff, x1_in;
   logic [YW-1:0]     y_ff, y_in, y1_ff, y1_in;
   logic [3:0]        step_ff, step_in;
   logic signed [49:0] prod_ff;
   logic signed [EW-1:0] ed_ff [4];
   logic signed [EW-1:0] ed_in [4];
   logic signed [EW-1:0] ecur_ff [3];
   logic signed [EW-1:0] ecur_in [3];
   logic signed [EW-1:0] erow_ff [3];
   logic signed [EW-1:0] erow_in [3];
   logic [MW-1:0]     am_ff, am_in;
   logic [NW-1:0]     acc_ff, acc_in;
   logic [NWR-1:0]    wr_cnt_ff, wr_cnt_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic              clr_rsp_ff, clr_rsp_in;

   // active frame size
   logic [CFG_W-1:0] fw_act, fh_act, fwm1, fhm1;

   always_comb begin
      if (fw_ff == '0) fw_act = CFG_W'(1);
      else if (fw_ff > CFG_W'(MAX_WIDTH)) fw_act = CFG_W'(MAX_WIDTH);
      else fw_act = fw_ff;
      if (fh_ff == '0) fh_act = CFG_W'(1);
      else if (fh_ff > CFG_W'(MAX_HEIGHT)) fh_act = CFG_W'(MAX_HEIGHT);
      else fh_act = fh_ff;
   end
   assign fwm1 = fw_act - 1'b1;
   assign fhm1 = fh_act - 1'b1;

   // bounding box
   logic signed [15:0] minx, maxx, miny, maxy;
   logic signed [16:0] maxx_p, maxy_p;
   logic signed [13:0] fx0, fx1, fy0, fy1, x0c, x1c, y0c, y1c;
   logic signed [13:0] fwm1_s, fhm1_s;
   logic               box_empty;

   always_comb begin
      minx = (req_ff.ax < req_ff.bx) ? req_ff.ax : req_ff.bx;
      minx = (minx < req_ff.cx) ? minx : req_ff.cx;
      maxx = (req_ff.ax > req_ff.bx) ? req_ff.ax : req_ff.bx;
      maxx = (maxx > req_ff.cx) ? maxx : req_ff.cx;
      miny = (req_ff.ay < req_ff.by) ? req_ff.ay : req_ff.by;
      miny = (miny < req_ff.cy) ? miny : req_ff.cy;
      maxy = (req_ff.ay > req_ff.by) ? req_ff.ay : req_ff.by;
      maxy = (maxy > req_ff.cy) ? maxy : req_ff.cy;
      maxx_p = 17'(maxx) + 17'sd15;
      maxy_p = 17'(maxy) + 17'sd15;
      fx0 = 14'(minx >>> 4);
      fy0 = 14'(miny >>> 4);
      fx1 = 14'(maxx_p >>> 4);
      fy1 = 14'(maxy_p >>> 4);
      fwm1_s = signed'(14'(fwm1));
      fhm1_s = signed'(14'(fhm1));
      x0c = (fx0 < 14'sd0) ? 14'sd0 : fx0;
      y0c = (fy0 < 14'sd0) ? 14'sd0 : fy0;
      x1c = (fx1 > fwm1_s) ? fwm1_s : fx1;
      y1c = (fy1 > fhm1_s) ? fhm1_s : fy1;
      box_empty = (x0c > x1c) || (y0c > y1c);
   end

   // vertex differences, 13.4
   logic signed [16:0] d_bax, d_bay, d_cax, d_cay, d_cbx, d_cby, d_acx, d_acy;
   logic signed [16:0] px0, py0, pxa, pya, pxb, pyb, pxc, pyc;
   logic signed [EW-1:0] stepx [3];
   logic signed [EW-1:0] stepy [3];

   always_comb begin
      d_bax = 17'(req_ff.bx) - 17'(req_ff.ax);
      d_bay = 17'(req_ff.by) - 17'(req_ff.ay);
      d_cax = 17'(req_ff.cx) - 17'(req_ff.ax);
      d_cay = 17'(req_ff.cy) - 17'(req_ff.ay);
      d_cbx = 17'(req_ff.cx) - 17'(req_ff.bx);
      d_cby = 17'(req_ff.cy) - 17'(req_ff.by);
      d_acx = 17'(req_ff.ax) - 17'(req_ff.cx);
      d_acy = 17'(req_ff.ay) - 17'(req_ff.cy);
      px0 = signed'(17'({x_ff, 4'b0000}));
      py0 = signed'(17'({y_ff, 4'b0000}));
      pxa = px0 - 17'(req_ff.ax);
      pya = py0 - 17'(req_ff.ay);
      pxb = px0 - 17'(req_ff.bx);
      pyb = py0 - 17'(req_ff.by);
      pxc = px0 - 17'(req_ff.cx);
      pyc = py0 - 17'(req_ff.cy);
      // edge order: ab, bc, ca
      stepx[0] = -(EW'(d_bay) <<< 4);
      stepx[1] = -(EW'(d_cby) <<< 4);
      stepx[2] = EW'(d_cay) <<< 4;
      stepy[0] = EW'(d_bax) <<< 4;
      stepy[1] = EW'(d_cbx) <<< 4;
      stepy[2] = EW'(d_acx) <<< 4;
   end

   // edge magnitudes and coverage
   logic signed [EW-1:0] eneg [3];
   logic [MW-1:0]        emag [3];
   logic                 covered, all_pos, all_neg;

   always_comb begin
      all_pos = 1'b1;
      all_neg = 1'b1;
      for (int i = 0; i < 3; i++) begin
         eneg[i] = -ecur_ff[i];
         emag[i] = ecur_ff[i][EW-1] ? eneg[i][MW-1:0] : ecur_ff[i][MW-1:0];
         if (ecur_ff[i][EW-1]) all_pos = 1'b0;
         if (!ecur_ff[i][EW-1] && (ecur_ff[i] != '0)) all_neg = 1'b0;
      end
      covered = all_pos || all_neg;
   end

   // shared multiplier operand select
   logic signed [24:0] mul_a, mul_b;
   logic signed [49:0] prod_in;
   logic [MW-1:0]      mag_sel;
   logic [DW-1:0]      z_sel;

   always_comb begin
      unique case (step_ff[2:1])
         2'd0:    begin mag_sel = emag[1]; z_sel = req_ff.az; end
         2'd1:    begin mag_sel = emag[2]; z_sel = req_ff.bz; end
         default: begin mag_sel = emag[0]; z_sel = req_ff.cz; end
      endcase
      mul_a = '0;
      mul_b = '0;
      if (state_ff == S_SETUP) begin
         unique case (step_ff)
            4'd0:    begin mul_a = 25'(d_bax); mul_b = 25'(d_cay); end
            4'd1:    begin mul_a = 25'(d_bay); mul_b = 25'(d_cax); end
            4'd2:    begin mul_a = 25'(d_bax); mul_b = 25'(pya); end
            4'd3:    begin mul_a = 25'(d_bay); mul_b = 25'(pxa); end
            4'd4:    begin mul_a = 25'(d_cbx); mul_b = 25'(pyb); end
            4'd5:    begin mul_a = 25'(d_cby); mul_b = 25'(pxb); end
            4'd6:    begin mul_a = 25'(d_acx); mul_b = 25'(pyc); end
            4'd7:    begin mul_a = 25'(d_acy); mul_b = 25'(pxc); end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end else begin
         mul_a = step_ff[0] ? signed'({8'b0, mag_sel[MW-1:18]})
                            : signed'({7'b0, mag_sel[17:0]});
         mul_b = signed'({1'b0, z_sel});
      end
   end
   assign prod_in = mul_a * mul_b;

   // divider
   logic          div_start, div_done;
   logic [NW-1:0] div_num;
   logic [QW-1:0] div_quot;
   logic [DW-1:0] z_sat;
   logic          z_win;

   assign div_start = (state_ff == S_DEPTH) && (step_ff == 4'd7);
   assign div_num   = acc_ff + NW'(am_ff >> 1);
   assign z_sat     = div_quot[QW-1] ? '1 : div_quot[DW-1:0];
   assign z_win     = z_sat < depth_rd_ff;

   trzr_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (am_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // sequencer
   logic [2:0]     j;
   logic [NW-1:0]  pterm;
   rsp_type        rsp_zero;

   assign j        = 3'(step_ff - 1'b1);
   assign rsp_zero = '0;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      step_in      = step_ff;
      am_in        = am_ff;
      acc_in       = acc_ff;
      wr_cnt_in    = wr_cnt_ff;
      clr_in       = clr_ff;
      clr_rsp_in   = clr_rsp_ff;
      ed_in        = ed_ff;
      ecur_in      = ecur_ff;
      erow_in      = erow_ff;
      mem_we       = 1'b0;
      mem_waddr    = {y_ff, x_ff};
      mem_wdepth   = z_sat;
      mem_wcolor   = req_ff.fill_color;
      pterm        = NW'(unsigned'(prod_ff[47:0]));
      if (j[0]) pterm = pterm << 18;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_ff;
            mem_wdepth = FAR_DEPTH;
            mem_wcolor = BG_COLOR;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               if (clr_rsp_ff) begin
                  rsp_in       = rsp_zero;
                  rsp_valid_in = 1'b1;
                  state_in     = S_RESP;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_IDLE: begin
            if (req_bus.valid) begin
               req_in = req_bus.data;
               priority if (req_bus.data.command == CMD_CLEAR) begin
                  clr_in     = '0;
                  clr_rsp_in = 1'b1;
                  state_in   = S_CLEAR;
               end else if (req_bus.data.command == CMD_DRAW) begin
                  state_in = S_BOX;
               end else if (req_bus.data.command == CMD_READ) begin
                  state_in = S_READ;
               end else begin
                  rsp_in       = rsp_zero;
                  rsp_valid_in = 1'b1;
                  state_in     = S_RESP;
               end
            end
         end
         S_READ: begin
            if (req_ff.ax < 16'sd0 || req_ff.ay < 16'sd0
                || 17'(req_ff.ax) >= signed'(17'(fw_act))
                || 17'(req_ff.ay) >= signed'(17'(fh_act))) begin
               rsp_in         = rsp_zero;
               rsp_in.skipped = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = S_RESP;
            end else begin
               x_in     = req_ff.ax[XW-1:0];
               y_in     = req_ff.ay[YW-1:0];
               state_in = S_RDMEM;
            end
         end
         S_RDMEM: state_in = S_RDOUT;
         S_RDOUT: begin
            rsp_in             = rsp_zero;
            rsp_in.pixel_color = color_rd_ff;
            rsp_in.pixel_depth = depth_rd_ff;
            rsp_valid_in       = 1'b1;
            state_in           = S_RESP;
         end
         S_BOX: begin
            if (box_empty) begin
               rsp_in         = rsp_zero;
               rsp_in.skipped = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = S_RESP;
            end else begin
               x0_in     = x0c[XW-1:0];
               x1_in     = x1c[XW-1:0];
               y1_in     = y1c[YW-1:0];
               x_in      = x0c[XW-1:0];
               y_in      = y0c[YW-1:0];
               step_in   = '0;
               wr_cnt_in = '0;
               state_in  = S_SETUP;
            end
         end
         S_SETUP: begin
            // product k is registered, then folded into its edge next cycle
            step_in = step_ff + 1'b1;
            if (step_ff != 4'd0) begin
               if (!j[0]) ed_in[j[2:1]] = EW'(prod_ff);
               else ed_in[j[2:1]] = ed_ff[j[2:1]] - EW'(prod_ff);
            end
            if (step_ff == 4'd8) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (ed_ff[0] == '0) begin
               rsp_in         = rsp_zero;
               rsp_in.skipped = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = S_RESP;
            end else begin
               am_in = ed_ff[0][EW-1] ? MW'(-ed_ff[0]) : ed_ff[0][MW-1:0];
               for (int i = 0; i < 3; i++) begin
                  ecur_in[i] = ed_ff[i+1];
                  erow_in[i] = ed_ff[i+1];
               end
               state_in = S_TEST;
            end
         end
         S_TEST: begin
            if (covered) begin
               step_in  = '0;
               acc_in   = '0;
               state_in = S_DEPTH;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_DEPTH: begin
            step_in = step_ff + 1'b1;
            if (step_ff != 4'd0 && step_ff != 4'd7) acc_in = acc_ff + pterm;
            if (step_ff == 4'd7) state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (z_win) begin
               mem_we = 1'b1;
               if (wr_cnt_ff != '1) wr_cnt_in = wr_cnt_ff + 1'b1;
            end
            state_in = S_NEXT;
         end
         S_NEXT: begin
            if (x_ff == x1_ff) begin
               if (y_ff == y1_ff) begin
                  rsp_in                = rsp_zero;
                  rsp_in.pixels_written = wr_cnt_ff;
                  rsp_valid_in          = 1'b1;
                  state_in              = S_RESP;
               end else begin
                  y_in = y_ff + 1'b1;
                  x_in = x0_ff;
                  for (int i = 0; i < 3; i++) begin
                     erow_in[i] = erow_ff[i] + stepy[i];
                     ecur_in[i] = erow_ff[i] + stepy[i];
                  end
                  state_in = S_TEST;
               end
            end else begin
               x_in = x_ff + 1'b1;
               for (int i = 0; i < 3; i++) ecur_in[i] = ecur_ff[i] + stepx[i];
               state_in = S_TEST;
            end
         end
         S_RESP: begin
            if (rsp_bus.ready) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
         clr_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         step_ff      <= '0;
         fw_ff        <= CFG_W'(MAX_WIDTH);
         fh_ff        <= CFG_W'(MAX_HEIGHT);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_ff       <= clr_in;
         clr_rsp_ff   <= clr_rsp_in;
         step_ff      <= step_in;
         if (csr_we) begin
            if (csr_index == CSR_FRAME_WIDTH) fw_ff <= csr_wdata;
            if (csr_index == CSR_FRAME_HEIGHT) fh_ff <= csr_wdata;
         end
      end
      req_ff    <= req_in;
      rsp_ff    <= rsp_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      x0_ff     <= x0_in;
      x1_ff     <= x1_in;
      y1_ff     <= y1_in;
      prod_ff   <= prod_in;
      am_ff     <= am_in;
      acc_ff    <= acc_in;
      wr_cnt_ff <= wr_cnt_in;
      ed_ff     <= ed_in;
      ecur_ff   <= ecur_in;
      erow_ff   <= erow_in;
   end

   // frame stores, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         depth_mem[mem_waddr] <= mem_wdepth;
         color_mem[mem_waddr] <= mem_wcolor;
      end
      depth_rd_ff <= depth_mem[{y_ff, x_ff}];
      color_rd_ff <= color_mem[{y_ff, x_ff}];
   end

   assign req_bus.ready = (state_ff == S_IDLE);
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_ff;

endmodule

// ===== rtl/trzr_div.sv =====
// iterative restoring divider, one quotient bit per cycle
// depends on trzr_pkg; quotient must fit in QW bits

module trzr_div (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [trzr_pkg::NW-1:0] num,
   input  logic [trzr_pkg::MW-1:0] den,
   output logic                    done,
   output logic [trzr_pkg::QW-1:0] quot
);
   import trzr_pkg::*;

   localparam int RW = MW + 1;

   logic [RW-1:0]      rem_ff, rem_in;
   logic [QW-1:0]      lo_ff, lo_in;
   logic [QW-1:0]      q_ff, q_in;
   logic [MW-1:0]      den_ff, den_in;
   logic [$clog2(QW)-1:0] cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [RW:0]        trial;
   logic               ge;

   assign trial = {rem_ff, lo_ff[QW-1]};
   assign ge    = trial >= {2'b00, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // upper part is below the divisor since the quotient fits
         rem_in  = num[QW +: RW];
         lo_in   = num[QW-1:0];
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? RW'(trial - {2'b00, den_ff}) : trial[RW-1:0];
         lo_in  = {lo_ff[QW-2:0], 1'b0};
         q_in   = {q_ff[QW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ($clog2(QW))'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
      q_ff   <= q_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule
